// File: rtl/slip_weakening_friction_node_step_defines.svh
// assertion macros used by the friction node step
`ifndef SLIP_WEAKENING_FRICTION_NODE_STEP_DEFINES_SVH
`define SLIP_WEAKENING_FRICTION_NODE_STEP_DEFINES_SVH

`ifndef SYNTH
`define SFN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfn assertion failed");
`define SFN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfn assertion failed");
`else
`define SFN_ASSERT_IMPL(lbl, ante, cons)
`define SFN_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/sfn_pkg.sv
// types and constants of the slip weakening friction node step
`timescale 1ns / 1ps
package sfn_pkg;

  typedef struct packed {
    logic [9:0]         node;
    logic signed [31:0] normal_traction;
    logic [31:0]        shear_traction_norm;
    logic [31:0]        shear_slip_norm;
    logic               predict;
  } sfn_in_t;

  typedef struct packed {
    logic [9:0]         node_out;
    logic signed [31:0] clipped_normal;
    logic [16:0]        shear_scale;
    logic signed [31:0] reg_pressure;
  } sfn_out_t;

  typedef struct packed {
    logic [9:0]         node;
    logic signed [31:0] clipped;
    logic signed [31:0] press;
    logic [31:0]        shear;
  } sfn_carry_t;

  typedef enum logic [2:0] {
    MU_KEEP = 3'b001,
    MU_ADD  = 3'b010,
    MU_SAT  = 3'b100
  } sfn_mu_mode_t;

  localparam logic [2:0] CFG_MU_STATIC  = 3'd0;
  localparam logic [2:0] CFG_MU_KINETIC = 3'd1;
  localparam logic [2:0] CFG_INV_SLIP   = 3'd2;
  localparam logic [2:0] CFG_REG_EN     = 3'd3;
  localparam logic [2:0] CFG_RELAX_KEEP = 3'd4;

  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam int DIV_BITS = 16;
  localparam int DIV_LAT  = DIV_BITS + 1;

endpackage

// File: rtl/sfn_div.sv
// pipelined restoring divider for the shear scale, one quotient bit per stage
`timescale 1ns / 1ps
module sfn_div
  import sfn_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] strength,
  input  logic [31:0] den,
  output logic [16:0] scale
);

  logic [51:0]         rem_r [DIV_LAT];
  logic [51:0]         rem_nxt [DIV_LAT];
  logic [DIV_BITS-1:0] q_r [DIV_LAT];
  logic [DIV_BITS-1:0] q_nxt [DIV_LAT];
  logic                sat_r [DIV_LAT];
  logic                sat_nxt [DIV_LAT];
  logic [31:0]         den_r [DIV_LAT];
  logic [31:0]         den_nxt [DIV_LAT];
  logic [51:0]         num;
  logic [51:0]         dsh;

  assign num = {strength, 4'b0000};

  always_comb begin
    rem_nxt[0] = num;
    q_nxt[0]   = '0;
    sat_nxt[0] = (den == 32'd0) || (num >= {4'b0000, den, 16'h0000});
    den_nxt[0] = den;
    dsh        = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      dsh            = {20'h00000, den_r[j]} << (DIV_BITS - 1 - j);
      den_nxt[j+1]   = den_r[j];
      sat_nxt[j+1]   = sat_r[j];
      q_nxt[j+1]     = q_r[j];
      rem_nxt[j+1]   = rem_r[j];
      if (rem_r[j] >= dsh) begin
        rem_nxt[j+1]                    = rem_r[j] - dsh;
        q_nxt[j+1][DIV_BITS - 1 - j]    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_LAT; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        sat_r[j] <= sat_nxt[j];
        den_r[j] <= den_nxt[j];
      end
    end
  end

  assign scale = sat_r[DIV_LAT-1] ? Q16_ONE : {1'b0, q_r[DIV_LAT-1]};

endmodule

// File: rtl/slip_weakening_friction_node_step.sv
// slip weakening friction node step: pressure store, friction and shear scale
//
// in_valid/in_stall carries one node request per cycle while in_stall is low;
// out_valid/out_stall returns one result per request, in order. cfg_valid/
// cfg_ready writes the friction registers by index (ready is always high);
// write them only while the pipeline is empty.
// An accepted request passes stages 1 to 6, the divider stages and the output
// register; throughput is one request per cycle while in_stall is low, set by
// the single read and write port of the pressure memory, which is read at
// accept and written from stage 2, forwarding the two writes still in flight.
// After reset the block sweeps the pressure memory, one node per cycle, through
// all NODES entries, clearing the stored pressure and the seeded mark; in_stall
// is high during the sweep.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle.
`timescale 1ns / 1ps
`include "slip_weakening_friction_node_step_defines.svh"
module slip_weakening_friction_node_step
  import sfn_pkg::*;
#(
  parameter int NODES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  sfn_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output sfn_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  typedef logic [IW-1:0] wrap_tab_t [1024];

  function automatic wrap_tab_t build_wrap();
    wrap_tab_t t;
    for (int i = 0; i < 1024; i++) begin
      t[i] = IW'(i % NODES);
    end
    return t;
  endfunction

  localparam wrap_tab_t WRAP_TAB = build_wrap();

  // configuration
  logic [15:0] mu_s_r, mu_k_r;
  logic [31:0] inv_slip_r;
  logic        reg_en_r;
  logic [16:0] keep_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_s_r     <= '0;
      mu_k_r     <= '0;
      inv_slip_r <= 32'd65536;
      reg_en_r   <= 1'b0;
      keep_r     <= Q16_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MU_STATIC:  mu_s_r <= cfg_wdata[15:0];
        CFG_MU_KINETIC: mu_k_r <= cfg_wdata[15:0];
        CFG_INV_SLIP:   inv_slip_r <= cfg_wdata;
        CFG_REG_EN:     reg_en_r <= cfg_wdata[0];
        CFG_RELAX_KEEP: keep_r <= (cfg_wdata[16:0] > Q16_ONE) ? Q16_ONE : cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // control
  logic          adv;
  logic          acc;
  logic          clearing_r;
  logic [IW-1:0] clr_cnt_r;
  logic [IW-1:0] in_idx;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv || clearing_r;
  assign acc      = in_valid && !in_stall;

  if (NODES >= 1024) begin : g_wide
    assign in_idx = IW'(in_data.node);
  end else begin : g_wrap
    assign in_idx = WRAP_TAB[in_data.node];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == IW'(NODES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // pressure memory: seeded mark and pressure
  logic [32:0] pstore_r [NODES];
  logic [32:0] rd_q_r;

  // stage 1
  logic          s1_valid_r;
  sfn_in_t       s1_in_r;
  logic [IW-1:0] s1_idx_r;

  // stage 2
  logic               s2_valid_r;
  sfn_carry_t         s2_carry_r;
  logic [IW-1:0]      s2_idx_r;
  logic signed [31:0] s2_wdata_r;
  logic [63:0]        s2_r_r;

  // last write
  logic          lw_valid_r;
  logic [IW-1:0] lw_idx_r;
  logic [32:0]   lw_data_r;

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      pstore_r[clr_cnt_r] <= '0;
    end else if (adv && s2_valid_r) begin
      pstore_r[s2_idx_r] <= {1'b1, s2_wdata_r};
    end
    if (adv) begin
      rd_q_r <= pstore_r[in_idx];
    end
  end

  // stage 1 logic: forward, seed, blend
  logic [32:0]        ent;
  logic signed [31:0] p_old, c_val, blended, p_new, wdata;
  logic signed [17:0] k18, kc18;
  logic signed [49:0] pk, ck;
  logic signed [50:0] bsum;
  logic [63:0]        r_prod;

  always_comb begin
    priority if (s2_valid_r && s2_idx_r == s1_idx_r) begin
      ent = {1'b1, s2_wdata_r};
    end else if (lw_valid_r && lw_idx_r == s1_idx_r) begin
      ent = lw_data_r;
    end else begin
      ent = rd_q_r;
    end
    p_old   = ent[32] ? $signed(ent[31:0]) : s1_in_r.normal_traction;
    c_val   = s1_in_r.normal_traction[31] ? s1_in_r.normal_traction : 32'sd0;
    k18     = $signed({1'b0, keep_r});
    kc18    = $signed({1'b0, 17'(Q16_ONE - keep_r)});
    pk      = p_old * k18;
    ck      = c_val * kc18;
    bsum    = {pk[49], pk} + {ck[49], ck} + 51'sd32768;
    blended = bsum[47:16];
    if (!reg_en_r) begin
      p_new = c_val;
    end else if (c_val == 32'sd0) begin
      p_new = 32'sd0;
    end else begin
      p_new = blended;
    end
    wdata  = s1_in_r.predict ? p_old : p_new;
    r_prod = 64'(s1_in_r.shear_slip_norm) * 64'(inv_slip_r);
  end

  // stage 2 logic: friction case
  sfn_mu_mode_t mode;
  logic [47:0]  w_val;
  logic [15:0]  d_val;
  logic [32:0]  w_lo;
  logic [63:0]  w_hi;

  always_comb begin
    mode  = MU_KEEP;
    w_val = '0;
    d_val = '0;
    w_lo  = 33'h1_0000_0000 - {1'b0, s2_r_r[31:0]};
    w_hi  = s2_r_r - 64'h1_0000_0000;
    if (s2_r_r[63:32] == 32'd0 && mu_s_r > mu_k_r) begin
      mode  = MU_ADD;
      d_val = mu_s_r - mu_k_r;
      w_val = 48'(w_lo);
    end else if (s2_r_r > 64'h1_0000_0000 && mu_s_r < mu_k_r) begin
      d_val = mu_k_r - mu_s_r;
      w_val = w_hi[47:0];
      mode  = (w_hi[63:48] != 16'd0) ? MU_SAT : MU_ADD;
    end
  end

  // stages 3 to 6
  logic         s3_valid_r, s4_valid_r, s5_valid_r, s6_valid_r;
  sfn_carry_t   s3_carry_r, s4_carry_r, s5_carry_r, s6_carry_r;
  sfn_mu_mode_t s3_mode_r, s4_mode_r;
  logic [47:0]  s3_w_r;
  logic [15:0]  s3_d_r;
  logic [63:0]  s4_prod_r;
  logic [15:0]  s5_mu_r;
  logic [47:0]  s6_str_r;
  logic [64:0]  mu_rnd;
  logic [33:0]  mu_sum;
  logic [15:0]  mu_val;
  logic [31:0]  p_mag;

  always_comb begin
    mu_rnd = {1'b0, s4_prod_r} + 65'h0_8000_0000;
    mu_sum = {18'd0, mu_k_r} + {1'b0, mu_rnd[64:32]};
    unique case (s4_mode_r)
      MU_ADD:  mu_val = (mu_sum > 34'd65535) ? 16'hFFFF : mu_sum[15:0];
      MU_SAT:  mu_val = 16'hFFFF;
      default: mu_val = mu_k_r;
    endcase
    p_mag = s5_carry_r.press[31] ? 32'(-s5_carry_r.press) : s5_carry_r.press;
  end

  // divider stages
  logic       dv_valid_r [DIV_LAT];
  sfn_carry_t dv_carry_r [DIV_LAT];
  logic [16:0] scale;

  sfn_div u_div (
    .clk      (clk),
    .en       (adv),
    .strength (s6_str_r),
    .den      (s6_carry_r.shear),
    .scale    (scale)
  );

  logic     out_valid_r;
  sfn_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < DIV_LAT; j++) begin
        dv_valid_r[j] <= 1'b0;
      end
    end else if (adv) begin
      s1_valid_r    <= acc;
      s2_valid_r    <= s1_valid_r;
      lw_valid_r    <= s2_valid_r;
      s3_valid_r    <= s2_valid_r;
      s4_valid_r    <= s3_valid_r;
      s5_valid_r    <= s4_valid_r;
      s6_valid_r    <= s5_valid_r;
      dv_valid_r[0] <= s6_valid_r;
      for (int j = 1; j < DIV_LAT; j++) begin
        dv_valid_r[j] <= dv_valid_r[j-1];
      end
      out_valid_r <= dv_valid_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_in_r  <= in_data;
      s1_idx_r <= in_idx;

      s2_carry_r <= '{node: s1_in_r.node, clipped: c_val, press: p_new,
                      shear: s1_in_r.shear_traction_norm};
      s2_idx_r   <= s1_idx_r;
      s2_wdata_r <= wdata;
      s2_r_r     <= r_prod;

      lw_idx_r  <= s2_idx_r;
      lw_data_r <= {1'b1, s2_wdata_r};

      s3_carry_r <= s2_carry_r;
      s3_mode_r  <= mode;
      s3_w_r     <= w_val;
      s3_d_r     <= d_val;

      s4_carry_r <= s3_carry_r;
      s4_mode_r  <= s3_mode_r;
      s4_prod_r  <= 64'(s3_d_r) * 64'(s3_w_r);

      s5_carry_r <= s4_carry_r;
      s5_mu_r    <= mu_val;

      s6_carry_r <= s5_carry_r;
      s6_str_r   <= 48'(s5_mu_r) * 48'(p_mag);

      dv_carry_r[0] <= s6_carry_r;
      for (int j = 1; j < DIV_LAT; j++) begin
        dv_carry_r[j] <= dv_carry_r[j-1];
      end

      out_data_r <= '{node_out: dv_carry_r[DIV_LAT-1].node,
                      clipped_normal: dv_carry_r[DIV_LAT-1].clipped,
                      shear_scale: scale,
                      reg_pressure: dv_carry_r[DIV_LAT-1].press};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SFN_ASSERT_IMPL(a_no_accept_in_clear, clearing_r, in_stall)
  `SFN_ASSERT_IMPL(a_clear_after_reset, $past(!rst_n), clearing_r)
  `SFN_ASSERT_IMPL(a_scale_range, out_valid_r, out_data_r.shear_scale <= Q16_ONE)
  `SFN_ASSERT_IMPL(a_clip_nonpos, out_valid_r, out_data_r.clipped_normal <= 32'sd0)
  `SFN_ASSERT_NEXT(a_hold_on_stall, out_valid_r && out_stall, out_valid_r && $stable(s2_idx_r))

endmodule

// File: sim/slip_weakening_friction_node_step_test.sv
// testbench for the slip weakening friction node step: directed and randomized requests checked against a predictor
`timescale 1ns / 1ps
module slip_weakening_friction_node_step_test;
  import sfn_pkg::*;

  localparam int NODE_COUNT = 1024;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  sfn_in_t in_data;
  logic out_valid;
  logic out_stall;
  sfn_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  slip_weakening_friction_node_step #(.NODES(NODE_COUNT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [15:0] mu_s_q, mu_k_q;
  logic [31:0] inv_dc_q;
  logic regen_q;
  logic [16:0] keep_q;
  logic signed [31:0] press_mem [NODE_COUNT];
  logic seeded_mem [NODE_COUNT];

  sfn_in_t request_queue[$];
  sfn_out_t expected_results[$];
  int mismatches;
  int results_seen;
  int requests_sent;
  bit hold_off;
  bit driver_done;
  bit in_taken;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic signed [31:0] relax_pressure(logic signed [31:0] p,
      logic signed [31:0] c, logic [16:0] k);
    logic signed [63:0] x;
    logic signed [63:0] y;
    x = 64'(p) * $signed({47'd0, k}) + 64'(c) * $signed({47'd0, 17'd65536 - k});
    y = (x + 64'sd32768) >>> 16;
    return y[31:0];
  endfunction

  function automatic logic [15:0] friction_mu(logic [31:0] slip);
    logic [63:0] r;
    logic [63:0] mu;
    logic [63:0] one;
    one = 64'd1 << 32;
    r = 64'(slip) * 64'(inv_dc_q);
    mu = 64'(mu_k_q);
    if (r < one && mu_s_q > mu_k_q) begin
      mu += (64'(mu_s_q - mu_k_q) * (one - r) + (64'd1 << 31)) >> 32;
    end else if (r > one && mu_s_q < mu_k_q) begin
      if (r - one >= (64'd1 << 48)) mu = 64'd65535;
      else mu += (64'(mu_k_q - mu_s_q) * (r - one) + (64'd1 << 31)) >> 32;
    end
    if (mu > 64'd65535) mu = 64'd65535;
    return mu[15:0];
  endfunction

  function automatic sfn_out_t friction_step(sfn_in_t req);
    sfn_out_t res;
    logic signed [31:0] c;
    logic signed [31:0] p;
    logic [15:0] mu;
    logic [31:0] mag;
    logic [63:0] strength;
    logic [67:0] q;
    if (!seeded_mem[req.node]) begin
      press_mem[req.node] = req.normal_traction;
      seeded_mem[req.node] = 1'b1;
    end
    c = req.normal_traction < 0 ? req.normal_traction : 32'sd0;
    if (!regen_q) p = c;
    else if (c == 0) p = 0;
    else p = relax_pressure(press_mem[req.node], c, keep_q);
    if (!req.predict) press_mem[req.node] = p;
    mu = friction_mu(req.shear_slip_norm);
    mag = p < 0 ? 32'(-64'(p)) : p;
    strength = 64'(mu) * 64'(mag);
    if (req.shear_traction_norm == 0) begin
      res.shear_scale = Q16_ONE;
    end else begin
      q = {strength, 4'd0} / 68'(req.shear_traction_norm);
      res.shear_scale = q > 68'd65536 ? Q16_ONE : q[16:0];
    end
    res.node_out = req.node;
    res.clipped_normal = c;
    res.reg_pressure = p;
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MU_STATIC: mu_s_q = val[15:0];
      CFG_MU_KINETIC: mu_k_q = val[15:0];
      CFG_INV_SLIP: inv_dc_q = val;
      CFG_REG_EN: regen_q = val[0];
      default: keep_q = val[16:0] > 17'd65536 ? 17'd65536 : val[16:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(logic [9:0] node, logic [31:0] tn, logic [31:0] sh,
      logic [31:0] sl, logic pr);
    sfn_in_t r;
    r.node = node;
    r.normal_traction = tn;
    r.shear_traction_norm = sh;
    r.shear_slip_norm = sl;
    r.predict = pr;
    request_queue.push_back(r);
  endtask

  task automatic random_phase(int count);
    logic [9:0] base;
    base = $urandom_range(0, 1023);
    for (int i = 0; i < count; i++) begin
      // mostly a small set of nodes so regularization history builds up
      add_request($urandom_range(0, 3) == 0 ? 10'($urandom) : base + 10'($urandom_range(0, 7)),
        $urandom_range(0, 3) == 0 ? pick32() : -$signed(32'($urandom_range(0, 32'h00ff_ffff))),
        pick32(), pick32(), $urandom_range(0, 1));
    end
  endtask

  // driver
  int in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (in_taken) begin
      // just accepted at the previous rising edge
      if (in_gap == 0 && request_queue.size() > 1) begin
        void'(request_queue.pop_front());
        in_data <= request_queue[0];
        in_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
      end else begin
        void'(request_queue.pop_front());
        in_valid <= 1'b0;
        in_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) in_gap <= in_gap - 1;
      else if (request_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= request_queue[0];
      end
    end
  end

  // predictor runs on the accepting edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(friction_step(in_data));
      requests_sent++;
    end
  end

  // receiver stall
  int out_wait;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_wait <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 11) : 0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    sfn_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result node %0d", out_data.node_out);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.node_out !== out_data.node_out
            || exp_r.clipped_normal !== out_data.clipped_normal
            || exp_r.shear_scale !== out_data.shear_scale
            || exp_r.reg_pressure !== out_data.reg_pressure) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp node %0d cn %0d sc %0d p %0d, got node %0d cn %0d sc %0d p %0d",
              exp_r.node_out, exp_r.clipped_normal, exp_r.shear_scale, exp_r.reg_pressure,
              out_data.node_out, out_data.clipped_normal, out_data.shear_scale,
              out_data.reg_pressure);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MU_STATIC;
    cfg_wdata = '0;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    hold_off = 1'b0;
    mu_s_q = 0;
    mu_k_q = 0;
    inv_dc_q = 32'd65536;
    regen_q = 0;
    keep_q = 17'd65536;
    for (int i = 0; i < NODE_COUNT; i++) begin
      press_mem[i] = 0;
      seeded_mem[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, predict, zero shear, opened interface
    write_reg(CFG_MU_STATIC, 32'd2458);
    write_reg(CFG_MU_KINETIC, 32'd1638);
    write_reg(CFG_REG_EN, 32'd1);
    write_reg(CFG_RELAX_KEEP, 32'd40000);
    add_request(10'd0, 32'h8000_0000, 32'd0, 32'd0, 1'b0);
    add_request(10'd0, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_request(10'd0, -32'sd65536, 32'd65536, 32'd32768, 1'b1);
    add_request(10'd0, -32'sd65536, 32'd1, 32'd32768, 1'b0);
    add_request(10'd1023, 32'd0, 32'd0, 32'd0, 1'b1);
    add_request(10'd1023, -32'sd1, 32'd1, 32'd65536, 1'b0);
    add_request(10'd1, 32'd5, 32'd100, 32'd65535, 1'b1);
    add_request(10'd1, -32'sd300000, 32'd70000, 32'd65537, 1'b0);
    add_request(10'd2, -32'sd2147483647, 32'hffff_ffff, 32'd1, 1'b0);
    wait_idle();
    // static below kinetic, keep saturated, regularization still on
    write_reg(CFG_MU_STATIC, 32'd0);
    write_reg(CFG_MU_KINETIC, 32'hffff);
    write_reg(CFG_INV_SLIP, 32'hffff_ffff);
    write_reg(CFG_RELAX_KEEP, 32'h1ffff);
    add_request(10'd3, -32'sd1000000, 32'd1000, 32'd2, 1'b0);
    add_request(10'd3, -32'sd1000000, 32'd1000, 32'hffff_ffff, 1'b0);
    add_request(10'd4, -32'sd1000000, 32'd1000, 32'd0, 1'b0);
    wait_idle();
    write_reg(CFG_REG_EN, 32'd1);
    write_reg(CFG_REG_EN, 32'd0);
    add_request(10'd3, -32'sd5000, 32'd7, 32'd9, 1'b0);
    add_request(10'd5, 32'd5000, 32'd7, 32'd9, 1'b0);
    wait_idle();

    // random phases across several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MU_STATIC, ph == 0 ? 32'hffff : $urandom_range(0, 65535));
      write_reg(CFG_MU_KINETIC, ph == 1 ? 32'hffff : $urandom_range(0, 65535));
      write_reg(CFG_INV_SLIP, ph == 2 ? 32'd0 : $urandom);
      write_reg(CFG_REG_EN, 32'(ph % 3 != 2));
      write_reg(CFG_RELAX_KEEP, ph == 3 ? 32'd0 : $urandom_range(0, 17'h1ffff));
      if (ph == 2) begin
        // long receiver hold while requests keep coming
        hold_off = 1'b1;
        random_phase(RANDOM_ITEMS / 6);
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        random_phase(RANDOM_ITEMS / 6);
      end
      wait_idle();
    end

    $display("ran %0d requests over several friction settings, %0d results checked",
      requests_sent, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
